### rtl/core/qat_pkg.sv
package qat_pkg;

    typedef enum logic [3:0] {
        M_BETWEEN  = 4'd0,
        M_UNQ      = 4'd1,
        M_DQ       = 4'd2,
        M_DQ_ESC   = 4'd3,
        M_DQ_X0    = 4'd4,
        M_DQ_X1    = 4'd5,
        M_DQ_CLOSE = 4'd6,
        M_SQ       = 4'd7,
        M_SQ_BS    = 4'd8,
        M_SQ_CLOSE = 4'd9,
        M_DISCARD  = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_END  = 2'd1,
        K_LINE = 2'd2,
        K_ERR  = 2'd3
    } kind_t;

    localparam int MAX_RESULTS = 4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_A  = 8'h61;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] held;
        logic [7:0] count;
    } scan_state_t;

    typedef struct packed {
        logic [7:0] out_char;
        kind_t      kind;
        logic [7:0] arg_count;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] item;
        logic [2:0]                num;
    } group_t;

    function automatic logic is_blank(logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic logic is_sep(logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        return (c <= 8'h39) ? c[3:0] : 4'(c[3:0] + 4'd9);
    endfunction

    function automatic result_t mk_res(logic [7:0] ch, kind_t k, logic [7:0] cnt);
        result_t r;
        r.out_char  = (k == K_BYTE) ? ch : 8'd0;
        r.kind      = k;
        r.arg_count = (k == K_LINE) ? cnt : 8'd0;
        return r;
    endfunction

endpackage

### rtl/core/qat_in_if.sv
interface qat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       line_end;

    modport source (output valid, output in_char, output line_end, input ready);
    modport sink (input valid, input in_char, input line_end, output ready);
endinterface

### rtl/core/qat_out_if.sv
interface qat_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [1:0] kind;
    logic [7:0] arg_count;
    logic       last;

    modport source (output valid, output out_char, output kind, output arg_count,
                    output last, input ready);
    modport sink (input valid, input out_char, input kind, input arg_count,
                  input last, output ready);
endinterface

### rtl/core/qat_step.sv
module qat_step
    import qat_pkg::*;
#(
    parameter int MAX_ARGS = 255
)
(
    input  logic [7:0]  in_char,
    input  logic        line_end,
    input  scan_state_t state,
    output scan_state_t state_next,
    output group_t      grp
);

    localparam logic [7:0] CNT_CAP = 8'((MAX_ARGS < 255) ? MAX_ARGS : 255);

    always_comb
    begin
        logic [2:0]  n;
        logic [7:0]  c;
        logic [7:0]  e;
        logic        err;
        scan_state_t s;
        group_t      g;

        n   = 3'd0;
        c   = in_char;
        e   = in_char;
        err = 1'b0;
        s   = state;
        g   = '0;

        if (line_end)
        begin
            case (state.mode)
                M_UNQ, M_DQ_CLOSE, M_SQ_CLOSE:
                begin
                    g.item[n[1:0]] = mk_res(8'd0, K_END, 8'd0);
                    n = n + 3'd1;
                    if (s.count < CNT_CAP)
                        s.count = s.count + 8'd1;
                end
                M_DQ, M_SQ:
                    err = 1'b1;
                M_DQ_ESC, M_SQ_BS:
                begin
                    g.item[n[1:0]] = mk_res(CH_BSLASH, K_BYTE, 8'd0);
                    n = n + 3'd1;
                    err = 1'b1;
                end
                M_DQ_X0:
                begin
                    g.item[n[1:0]] = mk_res(CH_LOW_X, K_BYTE, 8'd0);
                    n = n + 3'd1;
                    err = 1'b1;
                end
                M_DQ_X1:
                begin
                    g.item[n[1:0]] = mk_res(CH_LOW_X, K_BYTE, 8'd0);
                    n = n + 3'd1;
                    g.item[n[1:0]] = mk_res(state.held, K_BYTE, 8'd0);
                    n = n + 3'd1;
                    err = 1'b1;
                end
                M_DISCARD:
                    s.count = 8'd0;
                default:
                    s.count = s.count;
            endcase
            if (err)
            begin
                g.item[n[1:0]] = mk_res(8'd0, K_ERR, 8'd0);
                n = n + 3'd1;
                s.count = 8'd0;
            end
            g.item[n[1:0]] = mk_res(8'd0, K_LINE, s.count);
            n = n + 3'd1;
            s.mode  = M_BETWEEN;
            s.held  = 8'd0;
            s.count = 8'd0;
        end
        else
        begin
            case (state.mode)
                M_UNQ:
                begin
                    if (is_sep(c))
                    begin
                        g.item[n[1:0]] = mk_res(8'd0, K_END, 8'd0);
                        n = n + 3'd1;
                        if (s.count < CNT_CAP)
                            s.count = s.count + 8'd1;
                        s.mode = M_BETWEEN;
                    end
                    else if (c == CH_DQUOTE)
                        s.mode = M_DQ;
                    else if (c == CH_SQUOTE)
                        s.mode = M_SQ;
                    else
                    begin
                        g.item[n[1:0]] = mk_res(c, K_BYTE, 8'd0);
                        n = n + 3'd1;
                    end
                end
                M_DQ_ESC:
                begin
                    if (c == CH_LOW_X)
                        s.mode = M_DQ_X0;
                    else
                    begin
                        if (c == CH_LOW_N)
                            e = CH_LF;
                        else if (c == CH_LOW_R)
                            e = CH_CR;
                        else if (c == CH_LOW_T)
                            e = CH_TAB;
                        else if (c == CH_LOW_B)
                            e = CH_BS;
                        else if (c == CH_LOW_A)
                            e = CH_BEL;
                        g.item[n[1:0]] = mk_res(e, K_BYTE, 8'd0);
                        n = n + 3'd1;
                        s.mode = M_DQ;
                    end
                end
                M_DQ, M_DQ_X0, M_DQ_X1:
                begin
                    if (state.mode == M_DQ_X0 && is_hex(c))
                    begin
                        s.held = c;
                        s.mode = M_DQ_X1;
                    end
                    else if (state.mode == M_DQ_X1 && is_hex(c))
                    begin
                        g.item[n[1:0]] = mk_res({hex_val(state.held), hex_val(c)},
                                                K_BYTE, 8'd0);
                        n = n + 3'd1;
                        s.mode = M_DQ;
                    end
                    else
                    begin
                        if (state.mode != M_DQ)
                        begin
                            g.item[n[1:0]] = mk_res(CH_LOW_X, K_BYTE, 8'd0);
                            n = n + 3'd1;
                        end
                        if (state.mode == M_DQ_X1)
                        begin
                            g.item[n[1:0]] = mk_res(state.held, K_BYTE, 8'd0);
                            n = n + 3'd1;
                        end
                        if (c == CH_BSLASH)
                            s.mode = M_DQ_ESC;
                        else if (c == CH_DQUOTE)
                            s.mode = M_DQ_CLOSE;
                        else
                        begin
                            g.item[n[1:0]] = mk_res(c, K_BYTE, 8'd0);
                            n = n + 3'd1;
                            s.mode = M_DQ;
                        end
                    end
                end
                M_DQ_CLOSE, M_SQ_CLOSE:
                begin
                    if (is_blank(c))
                    begin
                        g.item[n[1:0]] = mk_res(8'd0, K_END, 8'd0);
                        n = n + 3'd1;
                        if (s.count < CNT_CAP)
                            s.count = s.count + 8'd1;
                        s.mode = M_BETWEEN;
                    end
                    else
                    begin
                        g.item[n[1:0]] = mk_res(8'd0, K_ERR, 8'd0);
                        n = n + 3'd1;
                        s.mode = M_DISCARD;
                    end
                end
                M_SQ, M_SQ_BS:
                begin
                    if (state.mode == M_SQ_BS && c == CH_SQUOTE)
                    begin
                        g.item[n[1:0]] = mk_res(CH_SQUOTE, K_BYTE, 8'd0);
                        n = n + 3'd1;
                        s.mode = M_SQ;
                    end
                    else
                    begin
                        if (state.mode == M_SQ_BS)
                        begin
                            g.item[n[1:0]] = mk_res(CH_BSLASH, K_BYTE, 8'd0);
                            n = n + 3'd1;
                        end
                        if (c == CH_BSLASH)
                            s.mode = M_SQ_BS;
                        else if (c == CH_SQUOTE)
                            s.mode = M_SQ_CLOSE;
                        else
                        begin
                            g.item[n[1:0]] = mk_res(c, K_BYTE, 8'd0);
                            n = n + 3'd1;
                            s.mode = M_SQ;
                        end
                    end
                end
                M_DISCARD:
                    s.mode = M_DISCARD;
                default:
                begin
                    if (is_blank(c))
                        s.mode = M_BETWEEN;
                    else if (c == CH_DQUOTE)
                        s.mode = M_DQ;
                    else if (c == CH_SQUOTE)
                        s.mode = M_SQ;
                    else
                    begin
                        g.item[n[1:0]] = mk_res(c, K_BYTE, 8'd0);
                        n = n + 3'd1;
                        s.mode = M_UNQ;
                    end
                end
            endcase
        end

        g.num      = n;
        state_next = s;
        grp        = g;
    end

endmodule

### rtl/core/qat_obuf.sv
module qat_obuf
    import qat_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  group_t        grp,
    output logic          free,
    qat_out_if.source     tokens
);

    result_t [MAX_RESULTS-1:0] items_reg;
    logic [2:0]                num_reg;
    logic [2:0]                num_next;
    logic [1:0]                idx_reg;
    logic [1:0]                idx_next;
    logic                      at_last;
    result_t                   cur;

    assign cur     = items_reg[idx_reg];
    assign at_last = (3'({1'b0, idx_reg} + 3'd1) == num_reg);
    assign free    = (num_reg == 3'd0) || (tokens.ready && at_last);

    assign tokens.valid     = (num_reg != 3'd0);
    assign tokens.out_char  = cur.out_char;
    assign tokens.kind      = cur.kind;
    assign tokens.arg_count = cur.arg_count;
    assign tokens.last      = at_last;

    always_comb
    begin
        num_next = num_reg;
        idx_next = idx_reg;
        if (load)
        begin
            num_next = grp.num;
            idx_next = 2'd0;
        end
        else if (tokens.valid && tokens.ready)
        begin
            if (at_last)
            begin
                num_next = 3'd0;
                idx_next = 2'd0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            num_reg <= num_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            items_reg <= grp.item;
    end

endmodule

### rtl/core/quoted_argument_tokenizer.sv
// Channel  Dir  Payload                               Request
// bytes    in   in_char[7:0], line_end                one command-line byte or end of line
// tokens   out  out_char[7:0], kind[1:0],             one token byte, token end,
//               arg_count[7:0], last                  line end or error
//
// A byte request is registered and decoded combinationally; its 0..4 results
// load the result register, which drains one result per cycle unless tokens
// stalls. Requests are taken one per cycle while each gives at most one result
// and tokens does not stall; a request with more results holds the next one in
// the input register until its last result is taken. Reset empties both registers
// and clears the scan state; a tokens stall holds the input, back-pressuring bytes.
module quoted_argument_tokenizer
    import qat_pkg::*;
#(
    parameter int MAX_ARGS = 255
)
(
    input  logic      clk,
    input  logic      rst_n,
    qat_in_if.sink    bytes,
    qat_out_if.source tokens
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_end_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    group_t      grp;
    logic        grp_free;
    logic        advance;

    assign advance     = in_valid_reg && grp_free;
    assign bytes.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{mode: M_BETWEEN, held: 8'd0, count: 8'd0};
        end
        else
        begin
            if (bytes.ready)
                in_valid_reg <= bytes.valid;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            in_char_reg <= bytes.in_char;
            in_end_reg  <= bytes.line_end;
        end
    end

    qat_step #(
        .MAX_ARGS (MAX_ARGS)
    ) u_step (
        .in_char    (in_char_reg),
        .line_end   (in_end_reg),
        .state      (state_reg),
        .state_next (state_next),
        .grp        (grp)
    );

    qat_obuf u_obuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && (grp.num != 3'd0)),
        .grp    (grp),
        .free   (grp_free),
        .tokens (tokens)
    );

endmodule
